// ===== rtl/core/rbo_pkg.sv =====
// ----------------------------------------------------------------------------
// rbo_pkg: shared constants and types for the RGBA source-over blender
// Channel width, derived arithmetic widths and pipeline stage map.
// ----------------------------------------------------------------------------
package rbo_pkg;

   // channel width; full opacity is all ones
   localparam int CHANNEL_BITS = 8;
   localparam int NUM_CH       = 3;

   // arithmetic widths
   localparam int PROD_BITS = 2 * CHANNEL_BITS;        // c*a, den
   localparam int NUM_BITS  = 3 * CHANNEL_BITS;        // weighted numerator
   localparam int DIVD_BITS = 3 * CHANNEL_BITS + 2;    // 2*num + den
   localparam int DIVS_BITS = 2 * CHANNEL_BITS + 1;    // 2*den

   // pipeline map: two product stages, one operand stage, one stage per
   // quotient bit
   localparam int DIV_STAGES  = CHANNEL_BITS;
   localparam int ST_P1       = 0;
   localparam int ST_P2       = 1;
   localparam int ST_DV0      = 2;
   localparam int PIPE_STAGES = DIV_STAGES + 3;

   typedef logic [CHANNEL_BITS-1:0] channel_type;

   localparam channel_type CH_MAX = '1;

endpackage

// ===== rtl/core/rgba_alpha_blend_over.sv =====
// ----------------------------------------------------------------------------
// rgba_alpha_blend_over: straight-alpha source-over pixel compositor
// Lays a source RGBA pixel over a destination pixel with exact integer math:
// den = M*(A1+A2) - A1*A2, color = round(num/den), alpha = floor(den/M).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   req     | in        | req_valid/req_ready  | dst_* and src_* RGBA, 8b each
//   rsp     | out       | rsp_valid/rsp_ready  | out_* RGBA, 8b each
//
// One pixel per clock sustained while rsp_ready holds. The pipeline is two
// multiplier stages, one operand stage, then a restoring divider that
// resolves one quotient bit per stage.
// Each stage holds its own valid bit; an empty stage accepts even while the
// output waits, so bubbles collapse under a stall and nothing is dropped.
// Synchronous reset clears the valid bits only.
// Both alphas zero gives an all-zero pixel.
// ----------------------------------------------------------------------------
module rgba_alpha_blend_over (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rbo_pkg::channel_type req_dst_red,
   input  rbo_pkg::channel_type req_dst_green,
   input  rbo_pkg::channel_type req_dst_blue,
   input  rbo_pkg::channel_type req_dst_alpha,
   input  rbo_pkg::channel_type req_src_red,
   input  rbo_pkg::channel_type req_src_green,
   input  rbo_pkg::channel_type req_src_blue,
   input  rbo_pkg::channel_type req_src_alpha,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rbo_pkg::channel_type rsp_out_red,
   output rbo_pkg::channel_type rsp_out_green,
   output rbo_pkg::channel_type rsp_out_blue,
   output rbo_pkg::channel_type rsp_out_alpha
);
   import rbo_pkg::*;

   localparam int W = CHANNEL_BITS;

   // stage valid bits and ready chain
   logic [PIPE_STAGES-1:0] stg_vld_ff;
   logic [PIPE_STAGES-1:0] stg_rdy;

   // stage 1: products
   logic [PROD_BITS-1:0] p1_den_ff, p1_den_in;
   logic [PROD_BITS-1:0] p1_ca1_ff [NUM_CH];
   logic [PROD_BITS-1:0] p1_ca2_ff [NUM_CH];
   logic [PROD_BITS-1:0] p1_ca1_in [NUM_CH];
   logic [PROD_BITS-1:0] p1_ca2_in [NUM_CH];
   channel_type          p1_ma2_ff, p1_ma2_in;

   // stage 2: second products, alpha
   logic [PROD_BITS-1:0] p2_den_ff;
   logic [NUM_BITS-1:0]  p2_t_ff  [NUM_CH];
   logic [NUM_BITS-1:0]  p2_m2_ff [NUM_CH];
   logic [NUM_BITS-1:0]  p2_t_in  [NUM_CH];
   logic [NUM_BITS-1:0]  p2_m2_in [NUM_CH];
   channel_type          p2_alpha_ff, p2_alpha_in;

   // divider stages; index 0 holds the formed operands
   logic [DIVD_BITS-1:0] dv_rem_ff   [DIV_STAGES+1][NUM_CH];
   channel_type          dv_q_ff     [DIV_STAGES+1][NUM_CH];
   logic [DIVS_BITS-1:0] dv_dvs_ff   [DIV_STAGES+1];
   channel_type          dv_alpha_ff [DIV_STAGES+1];
   logic                 dv_zero_ff  [DIV_STAGES+1];

   channel_type dst_c [NUM_CH];
   channel_type src_c [NUM_CH];

   assign dst_c[0] = req_dst_red;
   assign dst_c[1] = req_dst_green;
   assign dst_c[2] = req_dst_blue;
   assign src_c[0] = req_src_red;
   assign src_c[1] = req_src_green;
   assign src_c[2] = req_src_blue;

   // ready ripples back from the output; an empty stage is always ready
   always_comb begin
      stg_rdy[PIPE_STAGES-1] = !stg_vld_ff[PIPE_STAGES-1] || rsp_ready;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         stg_rdy[i] = !stg_vld_ff[i] || stg_rdy[i+1];
      end
   end

   assign req_ready = stg_rdy[ST_P1];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
      end else begin
         if (stg_rdy[0]) begin
            stg_vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < PIPE_STAGES; i++) begin
            if (stg_rdy[i]) begin
               stg_vld_ff[i] <= stg_vld_ff[i-1];
            end
         end
      end
   end

   // stage 1: den = M*(a1+a2) - a1*a2, c*a products, M - a2
   logic [W:0]           alpha_sum;
   logic [PROD_BITS:0]   alpha_sum_m;
   logic [PROD_BITS-1:0] alpha_prod;

   always_comb begin
      alpha_sum   = {1'b0, req_dst_alpha} + {1'b0, req_src_alpha};
      alpha_sum_m = {alpha_sum, {W{1'b0}}} - {{W{1'b0}}, alpha_sum};
      alpha_prod  = {{W{1'b0}}, req_dst_alpha} * {{W{1'b0}}, req_src_alpha};
      p1_den_in   = alpha_sum_m[PROD_BITS-1:0] - alpha_prod;
      p1_ma2_in   = CH_MAX - req_src_alpha;
      for (int k = 0; k < NUM_CH; k++) begin
         p1_ca1_in[k] = {{W{1'b0}}, dst_c[k]} * {{W{1'b0}}, req_dst_alpha};
         p1_ca2_in[k] = {{W{1'b0}}, src_c[k]} * {{W{1'b0}}, req_src_alpha};
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[ST_P1]) begin
         p1_den_ff <= p1_den_in;
         p1_ma2_ff <= p1_ma2_in;
         p1_ca1_ff <= p1_ca1_in;
         p1_ca2_ff <= p1_ca2_in;
      end
   end

   // stage 2: c1*a1*(M-a2), M*c2*a2, alpha = floor(den/M)
   logic [PROD_BITS-1:0] alpha_acc;

   always_comb begin
      // floor(x/M) for x below M*M+M: (x + 1 + (x >> W)) >> W
      alpha_acc   = p1_den_ff + PROD_BITS'(1) + (p1_den_ff >> W);
      p2_alpha_in = alpha_acc[PROD_BITS-1:W];
      for (int k = 0; k < NUM_CH; k++) begin
         p2_t_in[k]  = {{W{1'b0}}, p1_ca1_ff[k]} * {{PROD_BITS{1'b0}}, p1_ma2_ff};
         p2_m2_in[k] = {p1_ca2_ff[k], {W{1'b0}}} - {{W{1'b0}}, p1_ca2_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[ST_P2]) begin
         p2_den_ff   <= p1_den_ff;
         p2_alpha_ff <= p2_alpha_in;
         p2_t_ff     <= p2_t_in;
         p2_m2_ff    <= p2_m2_in;
      end
   end

   // operand stage: dividend 2*num + den, divisor 2*den (round to nearest)
   logic [NUM_BITS:0] num_sum [NUM_CH];

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         num_sum[k] = {1'b0, p2_t_ff[k]} + {1'b0, p2_m2_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[ST_DV0]) begin
         for (int k = 0; k < NUM_CH; k++) begin
            dv_rem_ff[0][k] <= {num_sum[k], 1'b0}
                               + {{(DIVD_BITS-PROD_BITS){1'b0}}, p2_den_ff};
            dv_q_ff[0][k]   <= '0;
         end
         dv_dvs_ff[0]   <= {p2_den_ff, 1'b0};
         dv_alpha_ff[0] <= p2_alpha_ff;
         dv_zero_ff[0]  <= (p2_den_ff == '0);
      end
   end

   // restoring divider, one quotient bit per stage, MSB first
   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
      localparam int BIT = DIV_STAGES - s;

      logic [DIVD_BITS-1:0] dvs_shift;
      logic [DIVD_BITS-1:0] rem_in [NUM_CH];
      channel_type          q_in   [NUM_CH];

      always_comb begin
         dvs_shift = DIVD_BITS'(dv_dvs_ff[s-1]) << BIT;
         for (int k = 0; k < NUM_CH; k++) begin
            rem_in[k] = dv_rem_ff[s-1][k];
            q_in[k]   = dv_q_ff[s-1][k];
            if (dv_rem_ff[s-1][k] >= dvs_shift) begin
               rem_in[k]    = dv_rem_ff[s-1][k] - dvs_shift;
               q_in[k][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stg_rdy[ST_DV0+s]) begin
            dv_rem_ff[s]   <= rem_in;
            dv_q_ff[s]     <= q_in;
            dv_dvs_ff[s]   <= dv_dvs_ff[s-1];
            dv_alpha_ff[s] <= dv_alpha_ff[s-1];
            dv_zero_ff[s]  <= dv_zero_ff[s-1];
         end
      end
   end

   // result; both alphas zero forces a clear pixel
   assign rsp_valid     = stg_vld_ff[PIPE_STAGES-1];
   assign rsp_out_red   = dv_zero_ff[DIV_STAGES] ? '0 : dv_q_ff[DIV_STAGES][0];
   assign rsp_out_green = dv_zero_ff[DIV_STAGES] ? '0 : dv_q_ff[DIV_STAGES][1];
   assign rsp_out_blue  = dv_zero_ff[DIV_STAGES] ? '0 : dv_q_ff[DIV_STAGES][2];
   assign rsp_out_alpha = dv_alpha_ff[DIV_STAGES];

   // checks
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !dv_zero_ff[DIV_STAGES] |->
         (dv_rem_ff[DIV_STAGES][0] < DIVD_BITS'(dv_dvs_ff[DIV_STAGES])) &&
         (dv_rem_ff[DIV_STAGES][1] < DIVD_BITS'(dv_dvs_ff[DIV_STAGES])) &&
         (dv_rem_ff[DIV_STAGES][2] < DIVD_BITS'(dv_dvs_ff[DIV_STAGES])))
      else $error("divider remainder not below divisor");

   a_zero_tracks_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> dv_zero_ff[DIV_STAGES] == (dv_dvs_ff[DIV_STAGES] == '0))
      else $error("zero-alpha flag lost track of divisor");

   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stg_vld_ff[ST_P1])
      else $error("accepted transaction missing from first stage");

   a_stall_holds_first: assert property (@(posedge clock) disable iff (reset)
      stg_vld_ff[ST_P1] && !stg_rdy[ST_P1] |=>
         stg_vld_ff[ST_P1] && $stable(p1_den_ff) && $stable(p1_ma2_ff))
      else $error("stalled first stage changed");

endmodule

// ===== tb/sv/rgba_alpha_blend_over_tb.sv =====
// ----------------------------------------------------------------------------
// rgba_alpha_blend_over_tb: self-checking bench for the source-over blender
// A directed pass covers the opacity extremes and the both-transparent case.
// A random pass follows, with both sides idling at random. Each accepted
// transaction is turned into an expected pixel by an exact integer composite,
// and every returned pixel is compared field by field in order.
// ----------------------------------------------------------------------------
module rgba_alpha_blend_over_tb;
   import rbo_pkg::*;

   localparam int RANDOM_PIXELS = 1630;
   localparam int CALM_FIRST    = 700;
   localparam int CALM_LAST     = 999;
   localparam int IDLE_PCT      = 13;
   localparam int DRAIN_LIMIT   = 100000;

   typedef struct packed {
      channel_type red;
      channel_type green;
      channel_type blue;
      channel_type alpha;
   } rgba_type;

   // expected-pixel store plus the blend predictor
   class blend_scoreboard;
      rgba_type pending_pixels[$];
      int       mismatches = 0;

      // straight-alpha source over, exact quotient rounded half up
      function rgba_type composite_over(rgba_type dst, rgba_type src);
         longint unsigned full, a1, a2, den, num;
         longint unsigned c1[NUM_CH];
         longint unsigned c2[NUM_CH];
         channel_type     mixed[NUM_CH];
         rgba_type        result;
         int              k;
         full  = CH_MAX;
         a1    = dst.alpha;
         a2    = src.alpha;
         c1[0] = dst.red;
         c1[1] = dst.green;
         c1[2] = dst.blue;
         c2[0] = src.red;
         c2[1] = src.green;
         c2[2] = src.blue;
         result = '0;
         den = full * a1 + full * a2 - a1 * a2;
         // both layers transparent: black, transparent pixel
         if (den == 0)
            return result;
         for (k = 0; k < NUM_CH; k++) begin
            num = full * c1[k] * a1 + full * c2[k] * a2 - c1[k] * a1 * a2;
            mixed[k] = channel_type'((2 * num + den) / (2 * den));
         end
         result.red   = mixed[0];
         result.green = mixed[1];
         result.blue  = mixed[2];
         result.alpha = channel_type'(den / full);
         return result;
      endfunction

      function void note_pixel(rgba_type dst, rgba_type src);
         pending_pixels.insert(pending_pixels.size(), composite_over(dst, src));
      endfunction

      function void check_field(string name, channel_type want, channel_type got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(rgba_type got);
         rgba_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected result transaction: %h", got);
            mismatches++;
            return;
         end
         want = pending_pixels.pop_front();
         check_field("out_red", want.red, got.red);
         check_field("out_green", want.green, got.green);
         check_field("out_blue", want.blue, got.blue);
         check_field("out_alpha", want.alpha, got.alpha);
      endfunction

      function int outstanding();
         return pending_pixels.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   channel_type req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha;
   channel_type req_src_red, req_src_green, req_src_blue, req_src_alpha;
   logic        rsp_valid;
   logic        rsp_ready;
   channel_type rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;

   blend_scoreboard sb;
   bit              calm;

   rgba_alpha_blend_over dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_dst_red   (req_dst_red),
      .req_dst_green (req_dst_green),
      .req_dst_blue  (req_dst_blue),
      .req_dst_alpha (req_dst_alpha),
      .req_src_red   (req_src_red),
      .req_src_green (req_src_green),
      .req_src_blue  (req_src_blue),
      .req_src_alpha (req_src_alpha),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha)
   );

   always #5 clock = ~clock;

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // observe both channels at the edge where each transaction completes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_pixel({req_dst_red, req_dst_green, req_dst_blue, req_dst_alpha},
                          {req_src_red, req_src_green, req_src_blue, req_src_alpha});
         if (rsp_valid && rsp_ready)
            sb.check_pixel({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha});
      end
   end

   function automatic rgba_type rgba(int r, int g, int b, int a);
      rgba_type p;
      p.red   = channel_type'(r);
      p.green = channel_type'(g);
      p.blue  = channel_type'(b);
      p.alpha = channel_type'(a);
      return p;
   endfunction

   // opacity biased toward the corners of the blend
   function automatic channel_type pick_alpha();
      case ($urandom_range(9))
         0: return '0;
         1: return CH_MAX;
         2: return channel_type'(1);
         3: return CH_MAX - 1;
         default: return channel_type'($urandom);
      endcase
   endfunction

   function automatic rgba_type random_pixel();
      rgba_type p;
      p       = rgba_type'($urandom);
      p.alpha = pick_alpha();
      return p;
   endfunction

   // random idle cycles on the request side
   task automatic idle_request();
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_pixel(rgba_type dst, rgba_type src);
      idle_request();
      req_valid     <= 1'b1;
      req_dst_red   <= dst.red;
      req_dst_green <= dst.green;
      req_dst_blue  <= dst.blue;
      req_dst_alpha <= dst.alpha;
      req_src_red   <= src.red;
      req_src_green <= src.green;
      req_src_blue  <= src.blue;
      req_src_alpha <= src.alpha;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic run_directed();
      // fully transparent, with and without color behind it
      send_pixel(rgba(0, 0, 0, 0), rgba(0, 0, 0, 0));
      send_pixel(rgba(255, 255, 255, 0), rgba(170, 85, 255, 0));
      // opaque over opaque, opaque and half-opaque layers paired with transparent ones
      send_pixel(rgba(255, 255, 255, 255), rgba(0, 0, 0, 255));
      send_pixel(rgba(0, 0, 0, 255), rgba(255, 255, 255, 255));
      send_pixel(rgba(12, 200, 77, 255), rgba(255, 255, 255, 0));
      send_pixel(rgba(255, 255, 255, 0), rgba(33, 144, 250, 255));
      send_pixel(rgba(255, 0, 255, 0), rgba(10, 20, 30, 128));
      send_pixel(rgba(90, 180, 45, 128), rgba(255, 255, 255, 0));
      send_pixel(rgba(255, 255, 255, 255), rgba(255, 255, 255, 255));
      // barely visible and nearly opaque layers
      send_pixel(rgba(255, 255, 255, 1), rgba(0, 0, 0, 1));
      send_pixel(rgba(0, 0, 0, 1), rgba(255, 255, 255, 254));
      send_pixel(rgba(255, 0, 128, 254), rgba(0, 255, 127, 1));
      send_pixel(rgba(255, 255, 255, 254), rgba(0, 0, 0, 254));
      send_pixel(rgba(0, 0, 0, 255), rgba(255, 255, 255, 1));
      // alternating bit patterns on every field, then complementary colors at partial opacity
      send_pixel(rgba(170, 170, 170, 170), rgba(85, 85, 85, 85));
      send_pixel(rgba(85, 85, 85, 85), rgba(170, 170, 170, 170));
      send_pixel(rgba(0, 255, 0, 128), rgba(255, 0, 255, 128));
      send_pixel(rgba(1, 2, 3, 64), rgba(254, 253, 252, 192));
   endtask

   initial begin
      int guard;
      clock         = 1'b0;
      reset         = 1'b1;
      calm          = 1'b0;
      req_valid     = 1'b0;
      rsp_ready     = 1'b0;
      req_dst_red   = '0;
      req_dst_green = '0;
      req_dst_blue  = '0;
      req_dst_alpha = '0;
      req_src_red   = '0;
      req_src_green = '0;
      req_src_blue  = '0;
      req_src_alpha = '0;
      sb = new();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         calm = (i >= CALM_FIRST) && (i <= CALM_LAST);
         send_pixel(random_pixel(), random_pixel());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain the pipeline, then watch for stray results
      guard = 0;
      while (sb.outstanding() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (PIPE_STAGES + 4) @(posedge clock);

      if (sb.outstanding() != 0) begin
         $error("%0d expected pixels never returned", sb.outstanding());
         sb.mismatches++;
      end
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/rbo_pkg.sv
rtl/core/rgba_alpha_blend_over.sv
tb/sv/rgba_alpha_blend_over_tb.sv
